// ===== hdl/roman_numeral_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Roman numeral encoder assertion macros
// Shared property forms used by the encoder's checks.
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RNE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rne_pkg.sv =====
// ----------------------------------------------------------------------------
// rne_pkg
// Types, constants and helper functions shared by the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int VALUE_W   = 12;
    localparam int SYMBOL_W  = 8;
    localparam int QDEPTH    = 4;
    localparam int MAX_VALUE = 3000;

    // Numeral characters in internal form; SYM_NUL marks an empty slot or an error beat.
    typedef enum logic [2:0] {
        SYM_NUL,
        SYM_I,
        SYM_V,
        SYM_X,
        SYM_L,
        SYM_C,
        SYM_D,
        SYM_M
    } sym_t;

    // The characters for one decimal digit, first character in slot 0.
    typedef struct packed {
        logic [2:0]     len;
        sym_t [3:0]     code;
    } grp_t;

    // One classified item: thousands in group 0, ones in group 3.
    typedef struct packed {
        logic           inv;
        grp_t [3:0]     grp;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [SYMBOL_W-1:0] sym_ascii(sym_t s);
        logic [SYMBOL_W-1:0] a;
        case (s)
            SYM_I:   a = 8'h49;
            SYM_V:   a = 8'h56;
            SYM_X:   a = 8'h58;
            SYM_L:   a = 8'h4C;
            SYM_C:   a = 8'h43;
            SYM_D:   a = 8'h44;
            SYM_M:   a = 8'h4D;
            default: a = 8'h00;
        endcase
        return a;
    endfunction

    function automatic grp_t digit_pat(logic [3:0] d, sym_t one, sym_t five, sym_t ten);
        grp_t g;
        g.len     = 3'd0;
        g.code[0] = SYM_NUL;
        g.code[1] = SYM_NUL;
        g.code[2] = SYM_NUL;
        g.code[3] = SYM_NUL;
        case (d)
            4'd1:
            begin
                g.len = 3'd1;
                g.code[0] = one;
            end
            4'd2:
            begin
                g.len = 3'd2;
                g.code[0] = one;
                g.code[1] = one;
            end
            4'd3:
            begin
                g.len = 3'd3;
                g.code[0] = one;
                g.code[1] = one;
                g.code[2] = one;
            end
            4'd4:
            begin
                g.len = 3'd2;
                g.code[0] = one;
                g.code[1] = five;
            end
            4'd5:
            begin
                g.len = 3'd1;
                g.code[0] = five;
            end
            4'd6:
            begin
                g.len = 3'd2;
                g.code[0] = five;
                g.code[1] = one;
            end
            4'd7:
            begin
                g.len = 3'd3;
                g.code[0] = five;
                g.code[1] = one;
                g.code[2] = one;
            end
            4'd8:
            begin
                g.len = 3'd4;
                g.code[0] = five;
                g.code[1] = one;
                g.code[2] = one;
                g.code[3] = one;
            end
            4'd9:
            begin
                g.len = 3'd2;
                g.code[0] = one;
                g.code[1] = ten;
            end
            default:
            begin
                g.len = 3'd0;
            end
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/rne_front.sv =====
// ----------------------------------------------------------------------------
// rne_front
// Accepts numbers, splits them into decimal digits over two register stages
// and turns each digit into its character pattern for the queue.
// ----------------------------------------------------------------------------
module rne_front
    import rne_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_stall,
    input  logic [VALUE_W-1:0]  value,
    output logic                push,
    output entry_t              push_entry,
    input  q_stat_t             q_stat
);

    localparam logic [VALUE_W-1:0] THOU_TAB [4] =
        '{12'd0, 12'd1000, 12'd2000, 12'd3000};
    localparam logic [9:0] HUND_TAB [10] =
        '{10'd0, 10'd100, 10'd200, 10'd300, 10'd400,
          10'd500, 10'd600, 10'd700, 10'd800, 10'd900};
    localparam logic [6:0] TENS_TAB [10] =
        '{7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90};

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_inv_reg;
    logic [1:0] s1_th_reg;
    logic [9:0] s1_rem_reg;

    logic       s2_valid_reg, s2_valid_next;
    logic       s2_inv_reg;
    logic [1:0] s2_th_reg;
    logic [3:0] s2_hu_reg;
    logic [6:0] s2_rem_reg;

    logic       adv1, adv2;
    logic       inv_c;
    logic [1:0] th_c;
    logic [9:0] rem1_c;
    logic [3:0] hu_c;
    logic [6:0] rem2_c;
    logic [3:0] te_c;
    logic [3:0] on_c;

    assign adv2      = !s2_valid_reg || !q_stat.full;
    assign adv1      = !s1_valid_reg || adv2;
    assign num_stall = !adv1;
    assign push      = s2_valid_reg && !q_stat.full;

    always_comb
    begin
        inv_c = (value == '0) || (value > VALUE_W'(MAX_VALUE));
        th_c  = 2'd0;
        for (int k = 1; k <= 3; k++)
        begin
            if (value >= VALUE_W'(k * 1000))
            begin
                th_c = th_c + 2'd1;
            end
        end
        rem1_c = 10'(value - THOU_TAB[th_c]);
    end

    always_comb
    begin
        hu_c = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s1_rem_reg >= 10'(k * 100))
            begin
                hu_c = hu_c + 4'd1;
            end
        end
        rem2_c = 7'(s1_rem_reg - HUND_TAB[hu_c]);
    end

    always_comb
    begin
        te_c = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s2_rem_reg >= 7'(k * 10))
            begin
                te_c = te_c + 4'd1;
            end
        end
        on_c = 4'(s2_rem_reg - TENS_TAB[te_c]);
    end

    // An out-of-range number becomes one empty-symbol beat in the thousands group.
    always_comb
    begin
        push_entry.inv = s2_inv_reg;
        if (s2_inv_reg)
        begin
            push_entry.grp[0] = digit_pat(4'd1, SYM_NUL, SYM_NUL, SYM_NUL);
            push_entry.grp[1] = digit_pat(4'd0, SYM_NUL, SYM_NUL, SYM_NUL);
            push_entry.grp[2] = digit_pat(4'd0, SYM_NUL, SYM_NUL, SYM_NUL);
            push_entry.grp[3] = digit_pat(4'd0, SYM_NUL, SYM_NUL, SYM_NUL);
        end
        else
        begin
            push_entry.grp[0] = digit_pat({2'b00, s2_th_reg}, SYM_M, SYM_NUL, SYM_NUL);
            push_entry.grp[1] = digit_pat(s2_hu_reg, SYM_C, SYM_D, SYM_M);
            push_entry.grp[2] = digit_pat(te_c, SYM_X, SYM_L, SYM_C);
            push_entry.grp[3] = digit_pat(on_c, SYM_I, SYM_V, SYM_X);
        end
    end

    assign s1_valid_next = adv1 ? num_valid : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && num_valid)
        begin
            s1_inv_reg <= inv_c;
            s1_th_reg  <= th_c;
            s1_rem_reg <= rem1_c;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_inv_reg <= s1_inv_reg;
            s2_th_reg  <= s1_th_reg;
            s2_hu_reg  <= hu_c;
            s2_rem_reg <= rem2_c;
        end
    end

endmodule

// ===== hdl/rne_queue.sv =====
// ----------------------------------------------------------------------------
// rne_queue
// Small register queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module rne_queue
    import rne_pkg::*;
#(
    parameter int DEPTH = QDEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/rne_back.sv =====
// ----------------------------------------------------------------------------
// rne_back
// Walks the head item group by group and sends one character per beat
// through an output register.
// ----------------------------------------------------------------------------
module rne_back
    import rne_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  entry_t              head,
    input  q_stat_t             q_stat,
    output logic                pop,
    output logic                sym_valid,
    input  logic                sym_stall,
    output logic [SYMBOL_W-1:0] symbol,
    output logic                last,
    output logic                invalid
);

    logic [3:0]             done_reg, done_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   ovalid_reg, ovalid_next;
    logic [SYMBOL_W-1:0]    symbol_reg;
    logic                   last_reg;
    logic                   inv_reg;

    logic [3:0] nonempty;
    logic [3:0] avail;
    logic [3:0] rest;
    logic [1:0] cur;
    logic       end_grp;
    logic       last_c;
    logic       ld;
    sym_t       code_c;

    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            nonempty[g] = (head.grp[g].len != 3'd0);
        end
        avail = nonempty & ~done_reg;
        // Lowest remaining group goes first: thousands before ones.
        cur = 2'd0;
        for (int g = 3; g >= 0; g--)
        begin
            if (avail[g])
            begin
                cur = 2'(g);
            end
        end
        code_c  = head.grp[cur].code[pos_reg];
        end_grp = (({1'b0, pos_reg} + 3'd1) == head.grp[cur].len);
        rest    = avail & ~(4'b0001 << cur);
        last_c  = end_grp && (rest == 4'b0000);
    end

    assign ld  = !q_stat.empty && (!ovalid_reg || !sym_stall);
    assign pop = ld && last_c;

    always_comb
    begin
        done_next   = done_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && sym_stall;
        if (ld)
        begin
            ovalid_next = 1'b1;
            if (last_c)
            begin
                done_next = 4'b0000;
                pos_next  = 2'd0;
            end
            else if (end_grp)
            begin
                done_next = done_reg | (4'b0001 << cur);
                pos_next  = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 4'b0000;
            pos_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= done_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            symbol_reg <= sym_ascii(code_c);
            last_reg   <= last_c;
            inv_reg    <= head.inv;
        end
    end

    assign sym_valid = ovalid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign invalid   = inv_reg;

endmodule

// ===== hdl/roman_numeral_encoder.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit number into its Roman numeral, one ASCII character a beat.
// ----------------------------------------------------------------------------
// The number channel (num_valid, num_stall, value) takes one number a beat.
// The symbol channel (sym_valid, sym_stall, symbol, last, invalid) gives the
// numeral's characters in reading order, with last set on the final one.
// A number of 0 or above 3000 gives a single beat with symbol 0, last and
// invalid set. Bits of value are all used; nothing above bit 11 exists.
// The front splits the number into digits over two register stages and
// pushes the digit patterns into a four-entry queue; the back walks the head
// entry and loads one character a cycle into the output register while
// sym_stall is low. A number's first character goes through both front
// stages, the queue and the output register. Throughput: one character
// per cycle while sym_stall is low, 1 to 14 characters a numeral; the
// output register is the limit. Numbers keep being taken while characters
// of earlier ones are still going out, until the queue and front fill.
// Reset empties the front stages, the queue and the output register.
// While sym_stall is high the output beat holds and the back waits; the
// front keeps taking numbers until the queue and both front stages are
// full, then raises num_stall.
// ----------------------------------------------------------------------------
`include "roman_numeral_encoder_assert.svh"

module roman_numeral_encoder
    import rne_pkg::*;
#(
    parameter int Q_DEPTH = QDEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_stall,
    input  logic [VALUE_W-1:0]  value,
    output logic                sym_valid,
    input  logic                sym_stall,
    output logic [SYMBOL_W-1:0] symbol,
    output logic                last,
    output logic                invalid
);

    logic       q_push;
    logic       q_pop;
    entry_t     q_in;
    entry_t     q_head;
    q_stat_t    q_stat;

    rne_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_valid  (num_valid),
        .num_stall  (num_stall),
        .value      (value),
        .push       (q_push),
        .push_entry (q_in),
        .q_stat     (q_stat)
    );

    rne_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .q_stat     (q_stat)
    );

    rne_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .symbol     (symbol),
        .last       (last),
        .invalid    (invalid)
    );

    `RNE_ASSERT_IMP(a_no_overflow, clk, rst_n, q_push, !q_stat.full, "queue push while full")
    `RNE_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty, "queue pop while empty")
    `RNE_ASSERT_IMP(a_invalid_beat, clk, rst_n, sym_valid && invalid, last && (symbol == 8'd0), "invalid beat is not a lone empty beat")
    `RNE_ASSERT_NEXT(a_run_gapless, clk, rst_n, sym_valid && !sym_stall && !last, sym_valid, "gap inside a numeral")

endmodule
